// ===== sv/gga_pkg.sv =====
// Shared constants, codes and types of the grouped sum/count/average engine.
package gga_pkg;

  localparam int Groups     = 32;
  localparam int SamplesMax = 1048576;

  localparam int GroupW = 5;
  localparam int ScoreW = 10;
  localparam int SumW   = 31;
  localparam int CountW = 21;
  localparam int AvgW   = 18;
  localparam int FracW  = 8;

  localparam int AddrW = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int StepW = $clog2(AvgW);
  localparam int DvdW  = SumW + FracW;

  localparam logic [SumW-1:0]   SumMax   = '1;
  localparam logic [AvgW-1:0]   AvgMax   = '1;
  localparam logic [CountW-1:0] CountCap =
    CountW'((SamplesMax < (2**CountW - 1)) ? SamplesMax : (2**CountW - 1));
  localparam logic [StepW-1:0]  StepLast = StepW'(AvgW - 1);

  // Stream word layout
  localparam int InTdataW   = 16;
  localparam int OutSumLsb  = GroupW;
  localparam int OutCntLsb  = OutSumLsb + SumW;
  localparam int OutAvgLsb  = OutCntLsb + CountW;
  localparam int OutFieldW  = OutAvgLsb + AvgW;
  localparam int OutTdataW  = 80;
  localparam int OutTuserW  = 2;
  localparam int UserEmpty  = 0;
  localparam int UserSat    = 1;

  typedef enum logic {
    OpAccum = 1'b0,
    OpRead  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StCalc,
    StDiv,
    StDone
  } state_e;

  typedef struct packed {
    logic              sat;
    logic [CountW-1:0] count;
    logic [SumW-1:0]   sum;
  } entry_t;

endpackage

// ===== sv/grouped_sum_count_average.sv =====
// Top level of the grouped sum/count/average engine: group table, update and divider.
//
// Keyed aggregation over Groups groups. Each input word is a sample (tuser = 0) that
// adds its score to one group's sum and count, or a read (tuser = 1) of one group.
// Every input word yields exactly one output word with the group's sum, count and
// average after the item; the average is floor(sum * 256 / count), clamped to 18 bits.
//
// Channels: s_axis carries {score, group} in tdata and op in tuser; m_axis carries
// {average, count, sum, group} in tdata and {saturated, empty} in tuser.
//
// Timing: one item is in flight at a time. The group entry is read from a synchronous
// memory, updated and written back, then the average is produced by a restoring
// divider that retires one quotient bit per cycle. The divider is skipped when the
// group is empty or the average clamps; the output word is then registered from the
// StDone state.
//
// Reset clears every group at once through per-entry valid bits; a group never
// written reads as zero. The output word sits in its own register: a stalled
// receiver holds it, and the next item runs up to its divider result and then
// waits for the register to free before finishing.
module grouped_sum_count_average
  import gga_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [4:0] group, [14:5] score, [15] zero
  input  logic                 s_axis_tuser,   // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [4:0] group_out, [35:5] group_sum,
                                               // [56:36] group_count,
                                               // [74:57] group_average, [79:75] zero
  output logic [OutTuserW-1:0] m_axis_tuser    // [0] empty_res, [1] saturated
);

  // Group table: synchronous memory plus reset-cleared valid bits
  entry_t              mem [Groups];
  entry_t              rd_q;
  logic [Groups-1:0]   vld_q, vld_d;

  state_e              state_q, state_d;

  // Item under work
  logic                op_q;
  logic [GroupW-1:0]   grp_q;
  logic [ScoreW-1:0]   score_q;
  logic                inrange_q;
  logic [AddrW-1:0]    addr_q;

  // Result and divider
  logic [SumW-1:0]     res_sum_q, res_sum_d;
  logic [CountW-1:0]   res_cnt_q, res_cnt_d;
  logic                res_sat_q, res_sat_d;
  logic [CountW-1:0]   rem_q, rem_d;
  logic [AvgW-1:0]     dvd_q, dvd_d;
  logic [AvgW-1:0]     quo_q, quo_d;
  logic [StepW-1:0]    step_q, step_d;

  // Output register
  logic                out_vld_q, out_vld_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;
  logic [OutTuserW-1:0] out_user_q, out_user_d;

  logic                in_acc;
  logic                out_acc;
  logic [AddrW-1:0]    addr_in;
  logic                inrange_in;

  entry_t              ent;
  entry_t              wr_ent;
  logic                wr_en;
  logic [SumW:0]       sum_ext;
  logic [SumW-1:0]     new_sum;
  logic [CountW-1:0]   new_cnt;
  logic                new_sat;
  logic [DvdW-1:0]     dvd_full;
  logic                avg_ovf;
  logic [CountW:0]     rem_sh;
  logic [CountW:0]     rem_sub;
  logic                rem_ge;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_vld_q && m_axis_tready;
  assign addr_in       = AddrW'(s_axis_tdata[GroupW-1:0]);
  assign inrange_in    = int'(s_axis_tdata[GroupW-1:0]) < Groups;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Read-modify-write of the addressed entry
  always_comb begin
    ent     = vld_q[addr_q] ? rd_q : '0;
    sum_ext = {1'b0, ent.sum} + (SumW + 1)'(score_q);
    new_sum = ent.sum;
    new_cnt = ent.count;
    new_sat = ent.sat;
    if (op_q == OpAccum) begin
      if (ent.count >= CountCap) begin
        new_sat = 1'b1;
      end else begin
        new_cnt = ent.count + CountW'(1);
        if (sum_ext > {1'b0, SumMax}) begin
          new_sum = SumMax;
          new_sat = 1'b1;
        end else begin
          new_sum = sum_ext[SumW-1:0];
        end
      end
    end
    if (!inrange_q) begin
      new_sum = '0;
      new_cnt = '0;
      new_sat = 1'b0;
    end
    wr_ent   = '{sat: new_sat, count: new_cnt, sum: new_sum};
    wr_en    = (state_q == StCalc) && inrange_q && (op_q == OpAccum);
    dvd_full = {new_sum, FracW'(0)};
    avg_ovf  = dvd_full >= {new_cnt, AvgW'(0)};
  end

  // One restoring step: the remainder always stays below the divisor
  always_comb begin
    rem_sh  = {rem_q, dvd_q[AvgW-1]};
    rem_ge  = rem_sh >= {1'b0, res_cnt_q};
    rem_sub = rem_sh - {1'b0, res_cnt_q};
  end

  always_comb begin
    state_d    = state_q;
    vld_d      = vld_q;
    res_sum_d  = res_sum_q;
    res_cnt_d  = res_cnt_q;
    res_sat_d  = res_sat_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    quo_d      = quo_q;
    step_d     = step_q;
    out_vld_d  = out_acc ? 1'b0 : out_vld_q;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StCalc;
      end
      StCalc: begin
        res_sum_d = new_sum;
        res_cnt_d = new_cnt;
        res_sat_d = new_sat;
        if (wr_en) begin
          vld_d[addr_q] = 1'b1;
        end
        if (new_cnt == '0) begin
          quo_d   = '0;
          state_d = StDone;
        end else if (avg_ovf) begin
          quo_d   = AvgMax;
          state_d = StDone;
        end else begin
          rem_d   = dvd_full[DvdW-1:AvgW];
          dvd_d   = dvd_full[AvgW-1:0];
          quo_d   = '0;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = rem_ge ? rem_sub[CountW-1:0] : rem_sh[CountW-1:0];
        dvd_d  = dvd_q << 1;
        quo_d  = {quo_q[AvgW-2:0], rem_ge};
        step_d = step_q + StepW'(1);
        if (step_q == StepLast) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // Hold until the output register is free
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = OutTdataW'({quo_q, res_cnt_q, res_sum_q, grp_q});
          out_user_d = '0;
          out_user_d[UserEmpty] = (res_cnt_q == '0);
          out_user_d[UserSat]   = res_sat_q;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= s_axis_tuser;
      grp_q     <= s_axis_tdata[GroupW-1:0];
      score_q   <= s_axis_tdata[GroupW +: ScoreW];
      inrange_q <= inrange_in;
      addr_q    <= addr_in;
    end
    res_sum_q  <= res_sum_d;
    res_cnt_q  <= res_cnt_d;
    res_sat_q  <= res_sat_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_ent;
    end
    if (in_acc) begin
      rd_q <= mem[addr_in];
    end
  end

endmodule

// ===== sv/gga_checker.sv =====
// Port-level checks of the grouped sum/count/average engine and their binding.
module gga_checker
  import gga_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [InTdataW-1:0]  s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic [OutTuserW-1:0] m_axis_tuser
);

  // One item at a time: input closes right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserEmpty] |->
      m_axis_tdata[OutFieldW-1:OutSumLsb] == '0)
    else $error("empty group with nonzero sum, count or average");

  a_count_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[UserEmpty] |->
      m_axis_tdata[OutAvgLsb-1:OutCntLsb] != '0)
    else $error("nonempty group with zero count");

endmodule

bind grouped_sum_count_average gga_checker u_gga_checker (.*);
